@@ design/lsra_pkg.sv @@
// Shared types and constants for the linear-scan register allocator.
package lsra_pkg;

    // Configuration register indexes (byte address is four times the index).
    localparam int unsigned REG_NUM_REGISTERS = 0;

    // Fixed widths of the result fields.
    localparam int unsigned RES_ID_BITS  = 16;
    localparam int unsigned RES_REG_BITS = 4;
    localparam int unsigned M_TDATA_BITS =
        ((2 * RES_ID_BITS + RES_REG_BITS + 7) / 8) * 8;
    localparam int unsigned M_TUSER_BITS = 2;
    localparam int unsigned NUM_REG_BITS = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_DECIDE,
        ST_SCAN,
        ST_EVICT,
        ST_FINISH
    } lsra_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic expire;
        logic alloc;
        logic spill;
        logic scan_start;
        logic scan_step;
        logic evict;
        logic emit;
    } lsra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic full;
        logic scan_last;
    } lsra_stat_t;

endpackage

@@ design/lsra_ctrl.sv @@
// Controller state machine of the linear-scan register allocator.
module lsra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lsra_pkg::lsra_stat_t stat,
    output lsra_pkg::lsra_cmd_t  cmd
);
    import lsra_pkg::*;

    lsra_state_t state_reg;
    lsra_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                cmd.expire = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.n_zero)
                begin
                    cmd.spill  = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (stat.full)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.alloc  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // The output register is free, or is being emptied this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/lsra_datapath.sv @@
// Datapath of the linear-scan register allocator: slot table, search and result.
module lsra_datapath #(
    parameter int MAX_REGS  = 16,
    parameter int LINE_BITS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lsra_pkg::lsra_cmd_t                   cmd,
    output lsra_pkg::lsra_stat_t                  stat,
    input  logic [lsra_pkg::NUM_REG_BITS-1:0]     num_registers,
    input  logic [ID_BITS-1:0]                    web_id,
    input  logic [LINE_BITS-1:0]                  start_line,
    input  logic [LINE_BITS-1:0]                  end_line,
    output logic [lsra_pkg::RES_ID_BITS-1:0]      web_id_res,
    output logic                                  spilled,
    output logic [lsra_pkg::RES_REG_BITS-1:0]     assigned_register,
    output logic                                  evicted_valid,
    output logic [lsra_pkg::RES_ID_BITS-1:0]      evicted_id
);
    import lsra_pkg::*;

    localparam int IDX_BITS = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CNT_BITS = $clog2(MAX_REGS + 1);
    localparam int NUMW     = (CNT_BITS > NUM_REG_BITS) ? CNT_BITS : NUM_REG_BITS;
    localparam int AW       = (IDX_BITS > RES_REG_BITS) ? IDX_BITS : RES_REG_BITS;
    localparam int IW       = (ID_BITS > RES_ID_BITS) ? ID_BITS : RES_ID_BITS;

    // Slot table.
    logic                 valid_reg [MAX_REGS];
    logic                 valid_next [MAX_REGS];
    logic [LINE_BITS-1:0] end_mem [MAX_REGS];
    logic [ID_BITS-1:0]   id_mem [MAX_REGS];
    logic [IDX_BITS-1:0]  regno_mem [MAX_REGS];
    logic [31:0]          age_mem [MAX_REGS];
    logic [MAX_REGS-1:0]  free_reg;
    logic [MAX_REGS-1:0]  free_next;
    logic [31:0]          insert_reg;

    // Current item.
    logic [ID_BITS-1:0]   cur_id_reg;
    logic [LINE_BITS-1:0] cur_start_reg;
    logic [LINE_BITS-1:0] cur_end_reg;

    // Largest-end search.
    logic [IDX_BITS-1:0]  scan_idx_reg;
    logic                 best_found_reg;
    logic [IDX_BITS-1:0]  best_idx_reg;
    logic [LINE_BITS-1:0] best_end_reg;
    logic [31:0]          best_dist_reg;
    logic [ID_BITS-1:0]   best_id_reg;
    logic [IDX_BITS-1:0]  best_regno_reg;

    // Pending result and output register.
    logic                 res_spill_reg;
    logic [IDX_BITS-1:0]  res_regno_reg;
    logic                 res_ev_reg;
    logic [ID_BITS-1:0]   res_evid_reg;
    logic [ID_BITS-1:0]   out_id_reg;
    logic                 out_spill_reg;
    logic [IDX_BITS-1:0]  out_regno_reg;
    logic                 out_ev_reg;
    logic [ID_BITS-1:0]   out_evid_reg;

    logic [NUMW-1:0]      num_ext;
    logic [NUMW-1:0]      n_eff_w;
    logic [CNT_BITS-1:0]  n_eff;
    logic [CNT_BITS-1:0]  active;
    logic                 reg_found;
    logic [IDX_BITS-1:0]  reg_idx;
    logic                 slot_found;
    logic [IDX_BITS-1:0]  slot_idx;
    logic                 alloc_ok;
    logic                 evict_ok;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [31:0]          scan_dist;
    logic                 scan_take;
    logic [AW-1:0]        regno_wide;
    logic [IW-1:0]        id_wide;
    logic [IW-1:0]        evid_wide;

    // Register count, clamped to the table size.
    assign num_ext = NUMW'(num_registers);
    assign n_eff_w = (num_ext > NUMW'(MAX_REGS)) ? NUMW'(MAX_REGS) : num_ext;
    assign n_eff   = CNT_BITS'(n_eff_w);

    always_comb
    begin
        active     = '0;
        reg_found  = 1'b0;
        reg_idx    = '0;
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = 0; i < MAX_REGS; i++)
        begin
            active = active + CNT_BITS'(valid_reg[i]);
        end
        // Lowest free register below the count; first empty slot.
        for (int i = MAX_REGS - 1; i >= 0; i--)
        begin
            if (free_reg[i] && (CNT_BITS'(i) < n_eff))
            begin
                reg_found = 1'b1;
                reg_idx   = IDX_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                slot_found = 1'b1;
                slot_idx   = IDX_BITS'(i);
            end
        end
    end

    assign stat.n_zero    = (n_eff == '0);
    assign stat.full      = (active >= n_eff);
    assign stat.scan_last = (scan_idx_reg == IDX_BITS'(MAX_REGS - 1));

    assign alloc_ok = cmd.alloc && reg_found && slot_found;
    assign evict_ok = cmd.evict && best_found_reg && (best_end_reg > cur_end_reg);
    assign wr_en    = alloc_ok || evict_ok;
    assign wr_idx   = alloc_ok ? slot_idx : best_idx_reg;

    // Search step: largest end, ties to the oldest insertion.
    assign scan_dist = insert_reg - age_mem[scan_idx_reg];
    assign scan_take = valid_reg[scan_idx_reg] &&
                       (!best_found_reg ||
                        (end_mem[scan_idx_reg] > best_end_reg) ||
                        ((end_mem[scan_idx_reg] == best_end_reg) &&
                         (scan_dist > best_dist_reg)));

    always_comb
    begin
        free_next = free_reg;
        for (int i = 0; i < MAX_REGS; i++)
        begin
            valid_next[i] = valid_reg[i];
        end
        if (cmd.expire)
        begin
            for (int i = 0; i < MAX_REGS; i++)
            begin
                if (valid_reg[i] && (end_mem[i] < cur_start_reg))
                begin
                    valid_next[i]           = 1'b0;
                    free_next[regno_mem[i]] = 1'b1;
                end
            end
        end
        if (alloc_ok)
        begin
            valid_next[slot_idx] = 1'b1;
            free_next[reg_idx]   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_REGS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            free_reg   <= '1;
            insert_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_REGS; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
            free_reg <= free_next;
            if (wr_en)
            begin
                insert_reg <= insert_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_idx]  <= cur_id_reg;
            end_mem[wr_idx] <= cur_end_reg;
            age_mem[wr_idx] <= insert_reg;
        end
        if (alloc_ok)
        begin
            regno_mem[slot_idx] <= reg_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_id_reg    <= web_id;
            cur_start_reg <= start_line;
            cur_end_reg   <= end_line;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_BITS'(1);
            if (scan_take)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= scan_idx_reg;
                best_end_reg   <= end_mem[scan_idx_reg];
                best_dist_reg  <= scan_dist;
                best_id_reg    <= id_mem[scan_idx_reg];
                best_regno_reg <= regno_mem[scan_idx_reg];
            end
        end
        if (cmd.spill)
        begin
            res_spill_reg <= 1'b1;
            res_regno_reg <= '0;
            res_ev_reg    <= 1'b0;
            res_evid_reg  <= '0;
        end
        else if (cmd.alloc)
        begin
            res_spill_reg <= !alloc_ok;
            res_regno_reg <= alloc_ok ? reg_idx : '0;
            res_ev_reg    <= 1'b0;
            res_evid_reg  <= '0;
        end
        else if (cmd.evict)
        begin
            res_spill_reg <= !evict_ok;
            res_regno_reg <= evict_ok ? best_regno_reg : '0;
            res_ev_reg    <= evict_ok;
            res_evid_reg  <= evict_ok ? best_id_reg : '0;
        end
        if (cmd.emit)
        begin
            out_id_reg    <= cur_id_reg;
            out_spill_reg <= res_spill_reg;
            out_regno_reg <= res_regno_reg;
            out_ev_reg    <= res_ev_reg;
            out_evid_reg  <= res_evid_reg;
        end
    end

    assign regno_wide        = AW'(out_regno_reg);
    assign id_wide           = IW'(out_id_reg);
    assign evid_wide         = IW'(out_evid_reg);
    assign web_id_res        = id_wide[RES_ID_BITS-1:0];
    assign spilled           = out_spill_reg;
    assign assigned_register = regno_wide[RES_REG_BITS-1:0];
    assign evicted_valid     = out_ev_reg;
    assign evicted_id        = evid_wide[RES_ID_BITS-1:0];

endmodule

@@ design/linear_scan_register_allocator_top.sv @@
// Top level of the linear-scan register allocator: stream ports, APB register, core.
//
// This block performs linear-scan register allocation on live intervals that
// arrive on the input stream in ascending start order, one request per
// interval, and returns exactly one result request per interval. Each
// interval first retires every active interval whose end line lies below its
// start line. If fewer intervals are active than the configured register
// count, it takes the lowest free register. A zero count spills it at once.
// Otherwise the active interval with the largest end line (oldest insertion
// on a tie) is found; if that end is beyond the new end, the old interval is
// evicted and reported and its register is reused, else the new interval is
// spilled. The block works on one interval at a time. An interval that does
// not need the search (it gets a register directly, or is spilled without
// one) goes through expiry, the decision and the hand-off of its result to
// the output register; the input is ready again once that hand-off is done.
// When all registers are taken, a search walks the slot table one slot per
// cycle and an eviction step follows before the hand-off. The result sits
// in an output register, so the next interval is accepted while a finished
// result still waits to be taken; that next interval then holds in its
// hand-off step until the waiting result is taken. The register count is set
// through the APB port at byte address 0 (reset value 16, values above
// MAX_REGS act as MAX_REGS) and should be written only while the block is
// idle.
module linear_scan_register_allocator_top #(
    parameter int MAX_REGS  = 16,
    parameter int LINE_BITS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // APB configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // Input stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: web_id, start_line, end_line (lowest bits first), zero padded.
    input  logic [((ID_BITS + 2 * LINE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: web_id_res, assigned_register, evicted_id (lowest bits first),
    // zero padded.
    output logic [lsra_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,
    // tuser: spilled, evicted_valid (lowest bit first).
    output logic [lsra_pkg::M_TUSER_BITS-1:0]      m_axis_tuser
);
    import lsra_pkg::*;

    localparam int PAD_BITS = M_TDATA_BITS - 2 * RES_ID_BITS - RES_REG_BITS;

    logic [NUM_REG_BITS-1:0] num_registers_reg;
    logic                    cfg_write;
    logic                    cfg_hit;
    lsra_cmd_t               cmd;
    lsra_stat_t              stat;
    logic [RES_ID_BITS-1:0]  web_id_res;
    logic                    spilled;
    logic [RES_REG_BITS-1:0] assigned_register;
    logic                    evicted_valid;
    logic [RES_ID_BITS-1:0]  evicted_id;

    // The register index is the byte address divided by four.
    assign pready    = 1'b1;
    assign cfg_hit   = (32'(paddr[2]) == REG_NUM_REGISTERS);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_registers_reg <= NUM_REG_BITS'(16);
        end
        else if (cfg_write && cfg_hit)
        begin
            num_registers_reg <= pwdata[NUM_REG_BITS-1:0];
        end
    end

    assign prdata = cfg_hit ? 32'(num_registers_reg) : 32'd0;

    // The controller sequences expiry, decision, search and result hand-off.
    lsra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the slot table and the result register.
    lsra_datapath #(
        .MAX_REGS  (MAX_REGS),
        .LINE_BITS (LINE_BITS),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .num_registers     (num_registers_reg),
        .web_id            (s_axis_tdata[ID_BITS-1:0]),
        .start_line        (s_axis_tdata[ID_BITS +: LINE_BITS]),
        .end_line          (s_axis_tdata[ID_BITS + LINE_BITS +: LINE_BITS]),
        .web_id_res        (web_id_res),
        .spilled           (spilled),
        .assigned_register (assigned_register),
        .evicted_valid     (evicted_valid),
        .evicted_id        (evicted_id)
    );

    assign m_axis_tdata = {{PAD_BITS{1'b0}}, evicted_id, assigned_register, web_id_res};
    assign m_axis_tuser = {evicted_valid, spilled};

endmodule
